// ===== sv/signed_integer_to_radix_text_top_assert.svh =====
// Assertion macros for the radix text converter.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_TOP_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SIRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SIRT_ASSERT_IMP(lbl, ante, cons, msg)
`define SIRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sirt_pkg.sv =====
// Types, constants and the digit glyph function of the radix text converter.
`default_nettype none
package sirt_pkg;
	typedef logic signed [31:0] value_t;
	typedef logic [31:0] mag_t;
	typedef logic [7:0] char_t;
	typedef logic [5:0] radix_t;

	localparam radix_t RADIX_RESET = 6'd10;
	localparam radix_t RADIX_MIN = 6'd2;
	localparam radix_t RADIX_MAX = 6'd36;
	localparam char_t MINUS_CHAR = 8'h2D;
	localparam char_t NUL_CHAR = 8'h00;
	localparam char_t CHAR_ZERO = 8'h30;
	localparam char_t CHAR_LETTER_BASE = 8'h57;
	localparam radix_t FIRST_LETTER_DIGIT = 6'd10;

	typedef struct packed {
		logic push;
		logic pop;
		char_t push_char;
	} stack_ctrl_t;

	function automatic char_t glyph(input radix_t d);
		char_t c;
		if (d < FIRST_LETTER_DIGIT) begin
			c = CHAR_ZERO + {2'b00, d};
		end else begin
			c = CHAR_LETTER_BASE + {2'b00, d};
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== sv/sirt_if.sv =====
// Valid/ready channel interfaces for the input values and the output characters.
`default_nettype none
interface sirt_in_if;
	import sirt_pkg::*;
	logic valid;
	logic ready;
	value_t value;
	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface sirt_out_if;
	import sirt_pkg::*;
	logic valid;
	logic ready;
	char_t text_char;
	logic last_char;
	modport source(output valid, output text_char, output last_char, input ready);
	modport sink(input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== sv/sirt_digit_stack.sv =====
// Shift-register stack that reverses the characters of one conversion.
`default_nettype none
module sirt_digit_stack #(
	parameter int DEPTH = 33,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sirt_pkg::stack_ctrl_t ctrl,
	output sirt_pkg::char_t       top_char,
	output logic [CNT_W-1:0]      count
);
	import sirt_pkg::*;

	char_t store_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic do_push;

	assign do_push = ctrl.push && (count_q < CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[0] <= ctrl.push_char;
			for (int i = 1; i < DEPTH; i++) begin
				store_q[i] <= store_q[i-1];
			end
		end else if (ctrl.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign top_char = store_q[0];
	assign count = count_q;
endmodule
`default_nettype wire

// ===== sv/signed_integer_to_radix_text_top.sv =====
// Top level of the signed integer to radix text converter.
//
// A 32-bit signed value enters on in_ch and leaves as ASCII text on out_ch, one
// character per beat, most significant first, with last_char set on the final beat.
// The base comes from the radix register at byte address 0 of the APB port; bases
// outside 2 to 36 give a single NUL beat. A negative value starts with a minus sign.
// A bit-serial restoring divider produces one quotient bit per cycle; the first
// character becomes valid once all digits, and the minus sign of a negative value,
// have been produced, and the others follow one per cycle while the receiver is ready.
// The next value can be accepted once the last character has entered the output
// register. An invalid base gives its NUL beat without any division.
// One value is converted at a time: in_ch.ready is high only while no conversion or
// drain is in progress, but the last character may still wait in the output register.
// When the receiver stalls, the output register holds its beat and the drain waits.
// Reset sets the radix to ten, empties the character stack and clears out_ch.valid.
`default_nettype none
`include "signed_integer_to_radix_text_top_assert.svh"
module signed_integer_to_radix_text_top #(
	parameter int MAX_CHARS = 33
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sirt_in_if.sink     in_ch,
	sirt_out_if.source  out_ch
);
	import sirt_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam logic REG_RADIX = 1'b0;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam logic [4:0] LAST_BIT = 5'd31;

	logic [1:0] state_q;
	radix_t radix_q;
	radix_t base_q;
	logic neg_q;
	mag_t div_q;
	radix_t rem_q;
	logic [4:0] bit_q;
	logic out_valid_q;
	char_t out_char_q;
	logic out_last_q;

	mag_t raw;
	mag_t mag;
	logic valid_base;
	logic in_fire;
	logic out_free;
	logic [6:0] trial;
	logic ge;
	radix_t rem_next;
	mag_t quo_next;
	logic digit_done;
	stack_ctrl_t stack_ctrl;
	char_t top_char;
	logic [CNT_W-1:0] count;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX) ? {26'd0, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
			radix_q <= pwdata[5:0];
		end
	end

	assign raw = mag_t'(in_ch.value);
	assign mag = raw[31] ? (~raw + 32'd1) : raw;
	assign valid_base = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign trial = {rem_q, div_q[31]};
	assign ge = trial >= {1'b0, base_q};
	assign rem_next = ge ? 6'(trial - {1'b0, base_q}) : trial[5:0];
	assign quo_next = {div_q[30:0], ge};
	assign digit_done = (bit_q == LAST_BIT);

	always_comb begin
		stack_ctrl.push = 1'b0;
		stack_ctrl.pop = 1'b0;
		stack_ctrl.push_char = NUL_CHAR;
		unique case (state_q)
			ST_IDLE: begin
				stack_ctrl.push = in_fire && !valid_base;
			end
			ST_DIV: begin
				stack_ctrl.push = digit_done;
				stack_ctrl.push_char = glyph(rem_next);
			end
			ST_SIGN: begin
				stack_ctrl.push = 1'b1;
				stack_ctrl.push_char = MINUS_CHAR;
			end
			ST_EMIT: begin
				stack_ctrl.pop = out_free;
			end
			default: begin
				stack_ctrl.push = 1'b0;
			end
		endcase
	end

	sirt_digit_stack #(
		.DEPTH(MAX_CHARS),
		.CNT_W(CNT_W)
	) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(stack_ctrl),
		.top_char(top_char),
		.count(count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					bit_q <= '0;
					if (in_fire) begin
						state_q <= valid_base ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + 5'd1;
					if (digit_done && quo_next == '0) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free && count == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q <= radix_q;
			neg_q <= raw[31];
			div_q <= mag;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= quo_next;
			rem_q <= digit_done ? '0 : rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_char_q <= top_char;
			out_last_q <= (count == CNT_W'(1));
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.text_char = out_char_q;
	assign out_ch.last_char = out_last_q;

	`SIRT_ASSERT_IMP(a_emit_not_empty, state_q == ST_EMIT, count != '0, "drain with empty stack")
	`SIRT_ASSERT_IMP(a_rem_below_base, state_q == ST_DIV, rem_q < base_q, "remainder not below base")
	`SIRT_ASSERT_NEXT(a_bad_base_one_char, in_fire && !valid_base, state_q == ST_EMIT && count == CNT_W'(1), "bad base must give one character")
endmodule
`default_nettype wire
